// ----- rtl/ed6_pkg.sv -----
// ----------------------------------------------------------------------------
// ed6_pkg
// Shared widths, types and lane control for the six-axis distance unit.
// ----------------------------------------------------------------------------
package ed6_pkg;

   // largest number of axes one position carries
   localparam int MAX_AXES = 6;

   localparam int COORD_W = 32;              // signed q16.16 coordinate
   localparam int MAG_W   = 32;              // magnitude of an axis difference
   localparam int SQ_W    = 2 * MAG_W;       // exact square
   localparam int SUM_W   = SQ_W + 3;        // sum of up to six squares
   localparam int ROOT_W  = 34;              // unsigned q18.16 distance
   localparam int RAD_W   = 2 * ROOT_W;      // radicand, even number of bits
   localparam int REM_W   = ROOT_W + 3;      // square root partial remainder

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [SQ_W-1:0]           sq_type;
   typedef logic [SUM_W-1:0]          sum_type;
   typedef logic [ROOT_W-1:0]         root_type;
   typedef logic [RAD_W-1:0]          rad_type;
   typedef logic [REM_W-1:0]          rem_type;

   // load enables for the two stages of every lane
   typedef struct packed {
      logic en_diff;
      logic en_sq;
   } lane_ctl_type;

endpackage

// ----- rtl/ed6_lane.sv -----
// ----------------------------------------------------------------------------
// ed6_lane
// One axis: absolute difference of two coordinates, then its exact square.
// ----------------------------------------------------------------------------
module ed6_lane
   import ed6_pkg::*;
(
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  coord_type    coord_a,
   input  coord_type    coord_b,
   output sq_type       sq
);

   logic signed [COORD_W:0] diff;
   logic signed [COORD_W:0] diff_abs;
   mag_type                 mag_in;
   mag_type                 mag_ff;
   sq_type                  sq_in;
   sq_type                  sq_ff;

   // 33-bit difference never overflows; magnitude fits in 32 bits
   always_comb begin
      diff     = $signed({coord_a[COORD_W-1], coord_a}) - $signed({coord_b[COORD_W-1], coord_b});
      diff_abs = diff[COORD_W] ? -diff : diff;
      mag_in   = diff_abs[MAG_W-1:0];
   end

   assign sq_in = SQ_W'(mag_ff) * SQ_W'(mag_ff);

   always_ff @(posedge clock) begin
      if (ctl.en_diff) begin
         mag_ff <= mag_in;
      end
      if (ctl.en_sq) begin
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

// ----- rtl/ed6_sum.sv -----
// ----------------------------------------------------------------------------
// ed6_sum
// Registered adder tree merging the lane squares into one exact sum.
// ----------------------------------------------------------------------------
module ed6_sum
   import ed6_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sq_type  sq [MAX_AXES],
   output logic    out_valid,
   input  logic    out_ready,
   output sum_type sum
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES:0]   move;

   logic [SQ_W:0]   pair_in [3];
   logic [SQ_W:0]   pair_ff [3];
   logic [SQ_W+1:0] quad_in;
   logic [SQ_W+1:0] quad_ff;
   logic [SQ_W:0]   rest_ff;
   sum_type         sum_in;
   sum_type         sum_ff;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      move[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         move[i] = !v_ff[i] || move[i+1];
      end
      v_in = {v_ff[STAGES-2:0], in_valid};
   end

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         pair_in[p] = (SQ_W+1)'(sq[2*p]) + (SQ_W+1)'(sq[2*p+1]);
      end
      quad_in = (SQ_W+2)'(pair_ff[0]) + (SQ_W+2)'(pair_ff[1]);
      sum_in  = SUM_W'(quad_ff) + SUM_W'(rest_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (move[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         pair_ff <= pair_in;
      end
      if (move[1]) begin
         quad_ff <= quad_in;
         rest_ff <= pair_ff[2];
      end
      if (move[2]) begin
         sum_ff <= sum_in;
      end
   end

   assign in_ready  = move[0];
   assign out_valid = v_ff[STAGES-1];
   assign sum       = sum_ff;

endmodule

// ----- rtl/ed6_sqrt.sv -----
// ----------------------------------------------------------------------------
// ed6_sqrt
// Pipelined restoring square root, one result bit per stage, rounded down.
// ----------------------------------------------------------------------------
module ed6_sqrt
   import ed6_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sum_type  radicand,
   output logic     out_valid,
   input  logic     out_ready,
   output root_type root
);

   localparam int STAGES = ROOT_W;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES:0]   move;

   rem_type  rem_ff  [STAGES-1];
   rad_type  rad_ff  [STAGES-1];
   root_type root_ff [STAGES];

   rem_type  src_rem  [STAGES];
   rad_type  src_rad  [STAGES];
   root_type src_root [STAGES];

   rem_type  rem_in  [STAGES];
   root_type root_in [STAGES];

   always_comb begin
      move[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         move[i] = !v_ff[i] || move[i+1];
      end
      v_in = {v_ff[STAGES-2:0], in_valid};
   end

   // stage sources: first stage starts from zero remainder and root
   assign src_rem[0]  = '0;
   assign src_root[0] = '0;
   assign src_rad[0]  = RAD_W'(radicand);

   for (genvar g = 1; g < STAGES; g++) begin : g_src
      assign src_rem[g]  = rem_ff[g-1];
      assign src_root[g] = root_ff[g-1];
      assign src_rad[g]  = rad_ff[g-1];
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_step
      rem_type shifted;
      rem_type trial;
      logic    fits;

      always_comb begin
         shifted    = {src_rem[g][ROOT_W:0], src_rad[g][RAD_W-1 -: 2]};
         trial      = {1'b0, src_root[g], 2'b01};
         fits       = (shifted >= trial);
         rem_in[g]  = fits ? (shifted - trial) : shifted;
         root_in[g] = {src_root[g][ROOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (move[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (move[i]) begin
            root_ff[i] <= root_in[i];
         end
      end
      for (int i = 0; i < STAGES - 1; i++) begin
         if (move[i]) begin
            rem_ff[i] <= rem_in[i];
            rad_ff[i] <= {src_rad[i][RAD_W-3:0], 2'b00};
         end
      end
   end

   assign in_ready  = move[0];
   assign out_valid = v_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];

endmodule

// ----- rtl/six_axis_euclidean_distance.sv -----
// ----------------------------------------------------------------------------
// six_axis_euclidean_distance
// Euclidean distance between two six-axis positions in q16.16 fixed point.
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction carries two positions (a_*, b_*), each axis
//   a signed q16.16 coordinate; taken when req_valid is high, req_stall low
//   rsp channel: one transaction per request, rsp_distance holds
//   floor(sqrt(sum of squared axis differences)) as unsigned q18.16
//   only the first AXIS_COUNT axes take part; the rest of the inputs are ignored
// pipeline and throughput
//   a request passes 2 lane stages (difference, square),
//   3 adder tree stages and 34 square root stages (one root bit each)
//   one transaction per cycle sustained while rsp_stall is low; the 32x32
//   square in each lane and the per-bit root stages set the clock, not the rate
// reset
//   synchronous reset empties every stage; requests in flight are dropped,
//   none is invented, and the datapath holds no other state
// backpressure
//   rsp_stall holds the response register; stages behind it keep filling
//   into empty slots, so requests are still taken until the pipe is full
// ----------------------------------------------------------------------------
module six_axis_euclidean_distance
   import ed6_pkg::*;
#(
   parameter int AXIS_COUNT = 6
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_a_x,
   input  logic signed [31:0]   req_a_y,
   input  logic signed [31:0]   req_a_z,
   input  logic signed [31:0]   req_a_rot_a,
   input  logic signed [31:0]   req_a_rot_b,
   input  logic signed [31:0]   req_a_rot_c,
   input  logic signed [31:0]   req_b_x,
   input  logic signed [31:0]   req_b_y,
   input  logic signed [31:0]   req_b_z,
   input  logic signed [31:0]   req_b_rot_a,
   input  logic signed [31:0]   req_b_rot_b,
   input  logic signed [31:0]   req_b_rot_c,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [33:0]          rsp_distance
);

   // positions gathered into per-axis arrays
   coord_type pos_a [MAX_AXES];
   coord_type pos_b [MAX_AXES];

   // lane stage valids: difference, then square
   logic         diff_v_ff;
   logic         sq_v_ff;
   logic         diff_move;
   logic         sq_move;
   lane_ctl_type lane_ctl;

   sq_type   sq_all [MAX_AXES];
   logic     sum_in_ready;
   logic     sum_valid;
   sum_type  sum;
   logic     root_in_ready;
   root_type root;

   assign pos_a[0] = req_a_x;
   assign pos_a[1] = req_a_y;
   assign pos_a[2] = req_a_z;
   assign pos_a[3] = req_a_rot_a;
   assign pos_a[4] = req_a_rot_b;
   assign pos_a[5] = req_a_rot_c;
   assign pos_b[0] = req_b_x;
   assign pos_b[1] = req_b_y;
   assign pos_b[2] = req_b_z;
   assign pos_b[3] = req_b_rot_a;
   assign pos_b[4] = req_b_rot_b;
   assign pos_b[5] = req_b_rot_c;

   // a stage advances when empty or when its successor advances
   assign sq_move   = !sq_v_ff || sum_in_ready;
   assign diff_move = !diff_v_ff || sq_move;

   assign lane_ctl.en_diff = diff_move;
   assign lane_ctl.en_sq   = sq_move;

   assign req_stall = !diff_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_v_ff <= 1'b0;
         sq_v_ff   <= 1'b0;
      end else begin
         if (diff_move) begin
            diff_v_ff <= req_valid;
         end
         if (sq_move) begin
            sq_v_ff <= diff_v_ff;
         end
      end
   end

   // one lane per used axis; unused axes feed zero into the tree
   for (genvar k = 0; k < MAX_AXES; k++) begin : g_lane
      if (k < AXIS_COUNT) begin : g_used
         ed6_lane u_lane (
            .clock   (clock),
            .ctl     (lane_ctl),
            .coord_a (pos_a[k]),
            .coord_b (pos_b[k]),
            .sq      (sq_all[k])
         );
      end else begin : g_unused
         assign sq_all[k] = '0;
      end
   end

   // merge the lane squares
   ed6_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_v_ff),
      .in_ready  (sum_in_ready),
      .sq        (sq_all),
      .out_valid (sum_valid),
      .out_ready (root_in_ready),
      .sum       (sum)
   );

   // last root stage doubles as the response register
   ed6_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (root_in_ready),
      .radicand  (sum),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .root      (root)
   );

   assign rsp_distance = root;

endmodule
